### design/bqcr_pkg.sv
// Shared constants and codes for the biquad filter with coefficient ramping.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package bqcr_pkg;

  localparam int DATA_W             = 32;
  localparam int COEF_CNT           = 5;
  localparam int DEF_MAX_CHAN       = 2;
  localparam int DEF_COEF_FRAC_BITS = 27;
  localparam int APB_ADDR_W         = 5;
  localparam int APB_DATA_W         = 32;
  localparam int NCH_W              = 2;
  localparam int MAX_DELTA_W        = 31;
  localparam int S_USER_W           = 3;

  localparam logic [NCH_W-1:0]       RESET_NUM_CHANNELS = NCH_W'(1);
  localparam logic [MAX_DELTA_W-1:0] RESET_MAX_DELTA    = MAX_DELTA_W'(4096);

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_TARGET_B0    = 3'd0,
    REG_TARGET_B1    = 3'd1,
    REG_TARGET_B2    = 3'd2,
    REG_TARGET_A1    = 3'd3,
    REG_TARGET_A2    = 3'd4,
    REG_NUM_CHANNELS = 3'd5,
    REG_MAX_DELTA    = 3'd6
  } reg_idx_e;

endpackage

### design/biquad_filter_coef_ramp_top.sv
// Direct-form-1 biquad over interleaved channels with coefficient ramping.
// Depends on bqcr_pkg; delay words held in an internal two-port memory.
`timescale 1ns / 1ps

// A sample transaction leaves the input register in the idle state and runs
// the multiply-accumulate sequence, where one 32x32 multiplier serves the five
// taps while the four delay words of the channel are read from and written
// back to the delay memory. During a ramp the first sample of a frame first
// steps each coefficient. In bypass a sample is copied to the output register.
// Enable, disable and clear transactions are handled in the idle state and
// give no output. An input register and an output register let the next
// transaction in while a result waits to be taken. Clear marks all delay words
// as zero at once; there is no clearing pass after reset.

module biquad_filter_coef_ramp_top #(
  parameter int MAX_CHAN       = bqcr_pkg::DEF_MAX_CHAN,
  parameter int COEF_FRAC_BITS = bqcr_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bqcr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bqcr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bqcr_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bqcr_pkg::DATA_W-1:0]     s_axis_tdata,   // [31:0] sample_in
  input  logic [bqcr_pkg::S_USER_W-1:0]   s_axis_tuser,   // [1:0] cmd, [2] immediate
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bqcr_pkg::DATA_W-1:0]     m_axis_tdata,   // [31:0] sample_out
  output logic                            m_axis_tuser    // [0] channel
);
  import bqcr_pkg::*;

  localparam int CH_W   = (MAX_CHAN > 1) ? $clog2(MAX_CHAN) : 1;
  localparam int DEPTH  = 4 * MAX_CHAN;
  localparam int ADDR_W = CH_W + 2;
  localparam int IDX_W  = 3;

  localparam logic [DATA_W-1:0] COEF_ONE   = DATA_W'(1) << COEF_FRAC_BITS;
  localparam logic [3:0]        MAX_CHAN_L = 4'(MAX_CHAN);
  localparam logic [IDX_W-1:0]  LAST_COEF  = IDX_W'(COEF_CNT - 1);
  localparam logic [IDX_W-1:0]  LAST_STEP  = IDX_W'(6);

  typedef enum logic [1:0] {
    MODE_BYPASS      = 2'd0,
    MODE_NORMAL      = 2'd1,
    MODE_RAMP_TARGET = 2'd2,
    MODE_RAMP_IDENT  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RAMP,
    ST_MAC,
    ST_BYPASS
  } state_e;

  // configuration registers
  logic [DATA_W-1:0]      target_q [COEF_CNT];
  logic [NCH_W-1:0]       num_ch_q;
  logic [MAX_DELTA_W-1:0] max_delta_q;

  logic     cfg_we;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q[0] <= COEF_ONE;
      for (int i = 1; i < COEF_CNT; i++) begin
        target_q[i] <= '0;
      end
      num_ch_q    <= RESET_NUM_CHANNELS;
      max_delta_q <= RESET_MAX_DELTA;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TARGET_B0, REG_TARGET_B1, REG_TARGET_B2,
        REG_TARGET_A1, REG_TARGET_A2: target_q[cfg_idx] <= pwdata;
        REG_NUM_CHANNELS:             num_ch_q <= pwdata[NCH_W-1:0];
        REG_MAX_DELTA:                max_delta_q <= pwdata[MAX_DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TARGET_B0, REG_TARGET_B1, REG_TARGET_B2,
      REG_TARGET_A1, REG_TARGET_A2: prdata = target_q[cfg_idx];
      REG_NUM_CHANNELS:             prdata = APB_DATA_W'(num_ch_q);
      REG_MAX_DELTA:                prdata = APB_DATA_W'(max_delta_q);
      default:                      prdata = '0;
    endcase
  end

  // input register
  logic              ib_valid_q;
  cmd_e              ib_cmd_q;
  logic              ib_imm_q;
  logic [DATA_W-1:0] ib_x_q;
  logic              ib_pop;

  assign s_axis_tready = ~ib_valid_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ib_cmd_q <= cmd_e'(s_axis_tuser[1:0]);
      ib_imm_q <= s_axis_tuser[2];
      ib_x_q   <= s_axis_tdata;
    end
  end

  // engine state
  state_e            state_q;
  mode_e             mode_q;
  logic [IDX_W-1:0]  idx_q;
  logic [COEF_CNT-1:0] dirty_q;
  logic [CH_W-1:0]   pos_q;
  logic [DATA_W-1:0] coef_q [COEF_CNT];
  logic [DEPTH-1:0]  dvalid_q;
  logic              out_valid_q;

  // payload
  logic [CH_W-1:0]          ch_q;
  logic [DATA_W-1:0]        x_q;
  logic signed [63:0]       prod_q;
  logic [63:0]              acc_q;
  logic [DATA_W-1:0]        rd_data_q;
  logic                     rd_valid_q;
  logic [DATA_W-1:0]        d0_old_q;
  logic [DATA_W-1:0]        d2_old_q;
  logic [DATA_W-1:0]        out_data_q;
  logic                     out_ch_q;
  logic [DATA_W-1:0]        dmem [DEPTH];

  // channel count in use
  logic [3:0]      n_raw, n_eff;
  logic [CH_W-1:0] ch_sel, pos_d;
  logic            ramping;

  assign n_raw   = (num_ch_q == '0) ? 4'd1 : 4'(num_ch_q);
  assign n_eff   = (n_raw > MAX_CHAN_L) ? MAX_CHAN_L : n_raw;
  assign ch_sel  = (4'(pos_q) >= n_eff) ? '0 : pos_q;
  assign pos_d   = (4'(ch_sel) + 4'd1 >= n_eff) ? '0 : CH_W'(4'(ch_sel) + 4'd1);
  assign ramping = (mode_q == MODE_RAMP_TARGET) || (mode_q == MODE_RAMP_IDENT);

  // ramp step on the coefficient picked by idx_q
  logic [DATA_W-1:0]    coef_rd, goal, coef_d;
  logic signed [32:0]   diff, md;
  logic [COEF_CNT-1:0]  dirty_d;
  logic                 step_done;

  assign coef_rd = (idx_q < IDX_W'(COEF_CNT)) ? coef_q[idx_q] : '0;
  assign goal    = (mode_q == MODE_RAMP_IDENT) ? ((idx_q == '0) ? COEF_ONE : '0)
                                               : target_q[idx_q];
  assign diff    = $signed({goal[DATA_W-1], goal}) - $signed({coef_rd[DATA_W-1], coef_rd});
  assign md      = $signed({2'b00, max_delta_q});

  always_comb begin
    coef_d    = coef_rd;
    dirty_d   = dirty_q;
    step_done = 1'b0;
    if (dirty_q[idx_q]) begin
      if (diff > md) begin
        coef_d = coef_rd + DATA_W'(max_delta_q);
      end else if (diff < -md) begin
        coef_d = coef_rd - DATA_W'(max_delta_q);
      end else begin
        coef_d          = goal;
        dirty_d[idx_q]  = 1'b0;
      end
    end
    step_done = (dirty_d == '0);
  end

  // multiply-accumulate operands
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic [DATA_W-1:0]        rd_word, y_val;
  logic                     out_free;

  assign rd_word  = rd_valid_q ? rd_data_q : '0;
  assign mul_a    = $signed(coef_rd);
  assign mul_b    = (idx_q == '0) ? $signed(x_q) : $signed(rd_word);
  assign y_val    = acc_q[COEF_FRAC_BITS +: DATA_W];
  assign out_free = ~out_valid_q | m_axis_tready;

  // delay memory access
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_ra, mem_wa;
  logic [DATA_W-1:0] mem_wd;

  always_comb begin
    mem_re = (state_q == ST_MAC) && (idx_q < IDX_W'(4));
    mem_ra = {ch_q, idx_q[1:0]};
    mem_we = 1'b0;
    mem_wa = {ch_q, 2'd0};
    mem_wd = x_q;
    if (state_q == ST_MAC) begin
      case (idx_q)
        IDX_W'(1): begin
          mem_we = 1'b1;
          mem_wa = {ch_q, 2'd0};
          mem_wd = x_q;
        end
        IDX_W'(2): begin
          mem_we = 1'b1;
          mem_wa = {ch_q, 2'd1};
          mem_wd = d0_old_q;
        end
        IDX_W'(4): begin
          mem_we = 1'b1;
          mem_wa = {ch_q, 2'd3};
          mem_wd = d2_old_q;
        end
        LAST_STEP: begin
          mem_we = out_free;
          mem_wa = {ch_q, 2'd2};
          mem_wd = y_val;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dmem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= dmem[mem_ra];
    end
  end

  assign ib_pop = (state_q == ST_IDLE) && ib_valid_q;

  logic out_load;
  assign out_load = out_free &&
                    ((state_q == ST_BYPASS) || (state_q == ST_MAC && idx_q == LAST_STEP));

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_BYPASS;
      idx_q       <= '0;
      dirty_q     <= '0;
      pos_q       <= '0;
      dvalid_q    <= '0;
      ib_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
      coef_q[0]   <= COEF_ONE;
      for (int i = 1; i < COEF_CNT; i++) begin
        coef_q[i] <= '0;
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        ib_valid_q <= 1'b1;
      end else if (ib_pop) begin
        ib_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (mem_re) begin
        rd_valid_q <= dvalid_q[mem_ra];
      end
      if (mem_we) begin
        dvalid_q[mem_wa] <= 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (ib_valid_q) begin
            case (ib_cmd_q)
              CMD_ENABLE, CMD_DISABLE: begin
                if (ib_imm_q) begin
                  for (int i = 0; i < COEF_CNT; i++) begin
                    coef_q[i] <= (ib_cmd_q == CMD_ENABLE) ? target_q[i]
                                 : ((i == 0) ? COEF_ONE : '0);
                  end
                  dirty_q <= '0;
                  mode_q  <= (ib_cmd_q == CMD_ENABLE) ? MODE_NORMAL : MODE_BYPASS;
                end else begin
                  dirty_q <= '1;
                  mode_q  <= (ib_cmd_q == CMD_ENABLE) ? MODE_RAMP_TARGET
                                                      : MODE_RAMP_IDENT;
                end
              end
              CMD_CLEAR: begin
                dvalid_q <= '0;
              end
              CMD_SAMPLE: begin
                pos_q <= pos_d;
                if (ch_sel == '0 && ramping) begin
                  state_q <= ST_RAMP;
                end else if (mode_q == MODE_BYPASS) begin
                  state_q <= ST_BYPASS;
                end else begin
                  state_q <= ST_MAC;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RAMP: begin
          coef_q[idx_q] <= coef_d;
          dirty_q       <= dirty_d;
          if (idx_q == LAST_COEF) begin
            idx_q <= '0;
            if (step_done && mode_q == MODE_RAMP_IDENT) begin
              mode_q  <= MODE_BYPASS;
              state_q <= ST_BYPASS;
            end else begin
              if (step_done) begin
                mode_q <= MODE_NORMAL;
              end
              state_q <= ST_MAC;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_MAC: begin
          if (idx_q != LAST_STEP) begin
            idx_q <= idx_q + 1'b1;
          end else if (out_free) begin
            idx_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_BYPASS: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ib_pop && ib_cmd_q == CMD_SAMPLE) begin
      ch_q <= ch_sel;
      x_q  <= ib_x_q;
    end
    if (state_q == ST_MAC) begin
      if (idx_q < IDX_W'(COEF_CNT)) begin
        prod_q <= mul_a * mul_b;
      end
      if (idx_q == '0) begin
        acc_q <= '0;
      end else if (idx_q <= IDX_W'(COEF_CNT)) begin
        acc_q <= acc_q + prod_q;
      end
      if (idx_q == IDX_W'(1)) begin
        d0_old_q <= rd_word;
      end
      if (idx_q == IDX_W'(3)) begin
        d2_old_q <= rd_word;
      end
    end
    if (out_load) begin
      out_data_q <= (state_q == ST_BYPASS) ? x_q : y_val;
      out_ch_q   <= ch_q[0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ch_q;

endmodule

### design/bqcr_checker.sv
// Port-level checks for biquad_filter_coef_ramp_top, bound to the top level.
// Depends on bqcr_pkg for the command codes and port widths.
`timescale 1ns / 1ps

module bqcr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [bqcr_pkg::S_USER_W-1:0]   s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bqcr_pkg::DATA_W-1:0]     m_axis_tdata,
  input logic                            m_axis_tuser
);
  import bqcr_pkg::*;

  logic [2:0] pend_q;
  logic       smp_in, smp_out;

  assign smp_in  = s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == CMD_SAMPLE);
  assign smp_out = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(smp_in) - 3'(smp_out);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output transaction changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 3'd0)
    else $error("output transaction without a pending sample");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more samples in flight than the block can hold");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 3'd3 |-> !s_axis_tready)
    else $error("input accepted with every stage occupied");

endmodule

bind biquad_filter_coef_ramp_top bqcr_checker u_bqcr_checker (.*);
